[rtl/pwcb_pkg.sv]
// Shared types and constants for the periodic wrap cell binning unit.
package pwcb_pkg;

    // Field widths fixed by the block's interface.
    localparam int POS_W      = 32;
    localparam int BOX_W      = 31;
    localparam int RECIP_W    = 32;
    localparam int CNT_W      = 30;
    localparam int FRAC_W     = 32;
    localparam int FRAC_LSB   = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_AXES   = 3;

    // Pipeline stages: box fraction, scaled values, partial cell, output.
    localparam int NUM_STAGES = 4;
    localparam int ST_FRAC    = 0;
    localparam int ST_SCALE   = 1;
    localparam int ST_MERGE   = 2;
    localparam int ST_OUT     = 3;

    // Axis slots.
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_LEN_X   = 3'd0,
        REG_BOX_LEN_Y   = 3'd1,
        REG_BOX_LEN_Z   = 3'd2,
        REG_RECIP_X     = 3'd3,
        REG_RECIP_Y     = 3'd4,
        REG_RECIP_Z     = 3'd5,
        REG_CELL_COUNTS = 3'd6
    } cfg_reg_t;

    // Reset values: unit box, reciprocal just below one, one cell per axis.
    localparam logic [BOX_W-1:0]   BOX_LEN_RESET     = 31'd65536;
    localparam logic [RECIP_W-1:0] RECIP_RESET       = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0]   CELL_COUNTS_RESET = 30'd1049601;

    // Box geometry as seen by the datapath.
    typedef struct packed {
        logic [NUM_AXES-1:0][BOX_W-1:0]   box_len;
        logic [NUM_AXES-1:0][RECIP_W-1:0] recip;
    } box_cfg_t;

    // Per-stage load enables from the pipeline control.
    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;
    } pipe_ctrl_t;

endpackage

[rtl/pwcb_if.sv]
// Channel interfaces for particles, results and configuration writes.
interface pwcb_particle_if
    import pwcb_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    last_in;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output last_in, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input last_in, output ready);
endinterface

interface pwcb_result_if
    import pwcb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [BOX_W-1:0] wrapped_x;
    logic [BOX_W-1:0] wrapped_y;
    logic [BOX_W-1:0] wrapped_z;
    logic [CNT_W-1:0] cell_index;
    logic             last_out;

    modport source (output valid, output wrapped_x, output wrapped_y,
                    output wrapped_z, output cell_index, output last_out,
                    input ready);
    modport sink   (input valid, input wrapped_x, input wrapped_y,
                    input wrapped_z, input cell_index, input last_out,
                    output ready);
endinterface

interface pwcb_cfg_if
    import pwcb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/periodic_wrap_cell_binning_unit.sv]
// Throughput: one particle per cycle while the output is not stalled, through four register stages
// (box fraction multiply, box and cell scaling multiplies, row merge, cell number and output register).
// A stalled output holds the pipeline; empty stages still fill behind it.
// Reset empties the pipeline and sets a unit box, a reciprocal of 2^32-1 and one cell per axis.
module periodic_wrap_cell_binning_unit
    import pwcb_pkg::*;
#(
    parameter int AXIS_CELL_BITS = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    pwcb_particle_if.sink   particle,
    pwcb_result_if.source   result,
    pwcb_cfg_if.sink        cfg
);

    box_cfg_t                  box_cfg;
    pipe_ctrl_t                ctrl;
    logic [AXIS_CELL_BITS-1:0] cells [NUM_AXES];
    logic signed [POS_W-1:0]   pos [NUM_AXES];
    logic [BOX_W-1:0]          wrapped [NUM_AXES];
    logic [AXIS_CELL_BITS-1:0] idx [NUM_AXES];

    // Configuration registers.
    pwcb_cfg #(
        .AXIS_CELL_BITS (AXIS_CELL_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .box_cfg (box_cfg),
        .cells_x (cells[AX_X]),
        .cells_y (cells[AX_Y]),
        .cells_z (cells[AX_Z])
    );

    // Handshake and stage control.
    pwcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (particle.valid),
        .in_last   (particle.last_in),
        .in_ready  (particle.ready),
        .out_valid (result.valid),
        .out_last  (result.last_out),
        .out_ready (result.ready),
        .ctrl      (ctrl)
    );

    assign pos[AX_X] = particle.pos_x;
    assign pos[AX_Y] = particle.pos_y;
    assign pos[AX_Z] = particle.pos_z;

    // One wrap lane per axis.
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        pwcb_axis #(
            .AXIS_CELL_BITS (AXIS_CELL_BITS)
        ) u_axis (
            .clk      (clk),
            .ctrl     (ctrl),
            .pos      (pos[a]),
            .recip    (box_cfg.recip[a]),
            .box_len  (box_cfg.box_len[a]),
            .cells    (cells[a]),
            .wrapped  (wrapped[a]),
            .cell_idx (idx[a])
        );
    end

    // Cell number and output register.
    pwcb_cell #(
        .AXIS_CELL_BITS (AXIS_CELL_BITS)
    ) u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .ix           (idx[AX_X]),
        .iy           (idx[AX_Y]),
        .iz           (idx[AX_Z]),
        .cx           (cells[AX_X]),
        .cy           (cells[AX_Y]),
        .wrapped_x_in (wrapped[AX_X]),
        .wrapped_y_in (wrapped[AX_Y]),
        .wrapped_z_in (wrapped[AX_Z]),
        .wrapped_x    (result.wrapped_x),
        .wrapped_y    (result.wrapped_y),
        .wrapped_z    (result.wrapped_z),
        .cell_index   (result.cell_index)
    );

endmodule

[rtl/pwcb_cfg.sv]
// Configuration register file holding box lengths, reciprocals and cell counts.
module pwcb_cfg
    import pwcb_pkg::*;
#(
    parameter int AXIS_CELL_BITS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    pwcb_cfg_if.sink                  cfg,
    output box_cfg_t                  box_cfg,
    output logic [AXIS_CELL_BITS-1:0] cells_x,
    output logic [AXIS_CELL_BITS-1:0] cells_y,
    output logic [AXIS_CELL_BITS-1:0] cells_z
);

    logic [BOX_W-1:0]   box_len_x_reg;
    logic [BOX_W-1:0]   box_len_y_reg;
    logic [BOX_W-1:0]   box_len_z_reg;
    logic [RECIP_W-1:0] recip_x_reg;
    logic [RECIP_W-1:0] recip_y_reg;
    logic [RECIP_W-1:0] recip_z_reg;
    logic [CNT_W-1:0]   cell_counts_reg;

    logic [AXIS_CELL_BITS-1:0] field_x;
    logic [AXIS_CELL_BITS-1:0] field_y;
    logic [AXIS_CELL_BITS-1:0] field_z;

    // Writes are always taken; an unknown index is ignored.
    assign cfg.ready = 1'b1;

    // Register writes, wider data is truncated to the register width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_len_x_reg   <= BOX_LEN_RESET;
            box_len_y_reg   <= BOX_LEN_RESET;
            box_len_z_reg   <= BOX_LEN_RESET;
            recip_x_reg     <= RECIP_RESET;
            recip_y_reg     <= RECIP_RESET;
            recip_z_reg     <= RECIP_RESET;
            cell_counts_reg <= CELL_COUNTS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_BOX_LEN_X:   box_len_x_reg   <= cfg.data[BOX_W-1:0];
                REG_BOX_LEN_Y:   box_len_y_reg   <= cfg.data[BOX_W-1:0];
                REG_BOX_LEN_Z:   box_len_z_reg   <= cfg.data[BOX_W-1:0];
                REG_RECIP_X:     recip_x_reg     <= cfg.data[RECIP_W-1:0];
                REG_RECIP_Y:     recip_y_reg     <= cfg.data[RECIP_W-1:0];
                REG_RECIP_Z:     recip_z_reg     <= cfg.data[RECIP_W-1:0];
                REG_CELL_COUNTS: cell_counts_reg <= cfg.data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Geometry towards the datapath.
    always_comb
    begin
        box_cfg.box_len[AX_X] = box_len_x_reg;
        box_cfg.box_len[AX_Y] = box_len_y_reg;
        box_cfg.box_len[AX_Z] = box_len_z_reg;
        box_cfg.recip[AX_X]   = recip_x_reg;
        box_cfg.recip[AX_Y]   = recip_y_reg;
        box_cfg.recip[AX_Z]   = recip_z_reg;
    end

    // Packed cell counts; an axis with a zero count behaves as one cell.
    assign field_x = cell_counts_reg[AX_X*AXIS_CELL_BITS +: AXIS_CELL_BITS];
    assign field_y = cell_counts_reg[AX_Y*AXIS_CELL_BITS +: AXIS_CELL_BITS];
    assign field_z = cell_counts_reg[AX_Z*AXIS_CELL_BITS +: AXIS_CELL_BITS];

    assign cells_x = (field_x == '0) ? AXIS_CELL_BITS'(1) : field_x;
    assign cells_y = (field_y == '0) ? AXIS_CELL_BITS'(1) : field_y;
    assign cells_z = (field_z == '0) ? AXIS_CELL_BITS'(1) : field_z;

endmodule

[rtl/pwcb_ctrl.sv]
// Pipeline control: stage valid bits, stall propagation and the batch marker.
module pwcb_ctrl
    import pwcb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    output logic       out_valid,
    output logic       out_last,
    input  logic       out_ready,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] last_reg;
    logic [NUM_STAGES-1:0] rdy;

    // A stage may load when it is empty or its content moves on.
    always_comb
    begin
        rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign ctrl.adv  = rdy;
    assign in_ready  = rdy[ST_FRAC];
    assign out_valid = valid_reg[ST_OUT];
    assign out_last  = last_reg[ST_OUT];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[ST_FRAC])
            begin
                valid_reg[ST_FRAC] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Batch marker follows the same load enables.
    always_ff @(posedge clk)
    begin
        if (rdy[ST_FRAC])
        begin
            last_reg[ST_FRAC] <= in_last;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (rdy[k])
            begin
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    // With the output stage empty the pipeline must be able to take a transaction.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[ST_OUT] |-> in_ready)
        else $error("input not ready although output stage is empty");

    // An accepted transaction always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[ST_FRAC])
        else $error("accepted transaction lost at pipeline entry");

    // A stalled item in the merge stage is kept.
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_MERGE] && !rdy[ST_OUT]) |=> valid_reg[ST_MERGE])
        else $error("stalled item dropped from merge stage");

endmodule

[rtl/pwcb_axis.sv]
// One coordinate axis: box fraction, wrapped position and axis cell index.
module pwcb_axis
    import pwcb_pkg::*;
#(
    parameter int AXIS_CELL_BITS = 10
) (
    input  logic                      clk,
    input  pipe_ctrl_t                ctrl,
    input  logic signed [POS_W-1:0]   pos,
    input  logic [RECIP_W-1:0]        recip,
    input  logic [BOX_W-1:0]          box_len,
    input  logic [AXIS_CELL_BITS-1:0] cells,
    output logic [BOX_W-1:0]          wrapped,
    output logic [AXIS_CELL_BITS-1:0] cell_idx
);

    localparam int PROD_W  = POS_W + RECIP_W + 1;
    localparam int BPROD_W = FRAC_W + BOX_W;
    localparam int CPROD_W = FRAC_W + AXIS_CELL_BITS;

    logic signed [PROD_W-1:0]  prod;
    logic [FRAC_W-1:0]         frac_reg;
    logic [BPROD_W-1:0]        box_prod;
    logic [CPROD_W-1:0]        cell_prod;
    logic [BOX_W-1:0]          wrapped_reg;
    logic [AXIS_CELL_BITS-1:0] idx_reg;

    // Position times reciprocal; the fractional part modulo one is the wrap.
    assign prod = pos * $signed({1'b0, recip});

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[ST_FRAC])
        begin
            frac_reg <= prod[FRAC_LSB +: FRAC_W];
        end
    end

    // Scale the fraction back by the box length and by the cell count.
    assign box_prod  = frac_reg * box_len;
    assign cell_prod = frac_reg * cells;

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[ST_SCALE])
        begin
            wrapped_reg <= box_prod[FRAC_W +: BOX_W];
            idx_reg     <= cell_prod[FRAC_W +: AXIS_CELL_BITS];
        end
    end

    assign wrapped  = wrapped_reg;
    assign cell_idx = idx_reg;

endmodule

[rtl/pwcb_cell.sv]
// Linear cell number from the axis indices, plus the output register.
module pwcb_cell
    import pwcb_pkg::*;
#(
    parameter int AXIS_CELL_BITS = 10
) (
    input  logic                      clk,
    input  pipe_ctrl_t                ctrl,
    input  logic [AXIS_CELL_BITS-1:0] ix,
    input  logic [AXIS_CELL_BITS-1:0] iy,
    input  logic [AXIS_CELL_BITS-1:0] iz,
    input  logic [AXIS_CELL_BITS-1:0] cx,
    input  logic [AXIS_CELL_BITS-1:0] cy,
    input  logic [BOX_W-1:0]          wrapped_x_in,
    input  logic [BOX_W-1:0]          wrapped_y_in,
    input  logic [BOX_W-1:0]          wrapped_z_in,
    output logic [BOX_W-1:0]          wrapped_x,
    output logic [BOX_W-1:0]          wrapped_y,
    output logic [BOX_W-1:0]          wrapped_z,
    output logic [CNT_W-1:0]          cell_index
);

    localparam int PART_W = 2 * AXIS_CELL_BITS;
    localparam int CELL_W = 3 * AXIS_CELL_BITS;

    logic [PART_W-1:0]         part_next;
    logic [PART_W-1:0]         part_reg;
    logic [AXIS_CELL_BITS-1:0] ix_reg;
    logic [BOX_W-1:0]          wx_mid_reg;
    logic [BOX_W-1:0]          wy_mid_reg;
    logic [BOX_W-1:0]          wz_mid_reg;
    logic [CELL_W-1:0]         cell_next;
    logic [CELL_W-1:0]         cell_reg;
    logic [BOX_W-1:0]          wx_out_reg;
    logic [BOX_W-1:0]          wy_out_reg;
    logic [BOX_W-1:0]          wz_out_reg;

    // Row within the plane: iy + iz * cy.
    assign part_next = PART_W'(iz) * PART_W'(cy) + PART_W'(iy);

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[ST_MERGE])
        begin
            part_reg   <= part_next;
            ix_reg     <= ix;
            wx_mid_reg <= wrapped_x_in;
            wy_mid_reg <= wrapped_y_in;
            wz_mid_reg <= wrapped_z_in;
        end
    end

    // Full cell number: ix + row * cx, always below the total cell count.
    assign cell_next = CELL_W'(ix_reg) + CELL_W'(part_reg) * CELL_W'(cx);

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[ST_OUT])
        begin
            cell_reg   <= cell_next;
            wx_out_reg <= wx_mid_reg;
            wy_out_reg <= wy_mid_reg;
            wz_out_reg <= wz_mid_reg;
        end
    end

    assign wrapped_x  = wx_out_reg;
    assign wrapped_y  = wy_out_reg;
    assign wrapped_z  = wz_out_reg;
    assign cell_index = CNT_W'(cell_reg);

endmodule

[test/periodic_wrap_cell_binning_unit_tb.sv]
// Self-checking testbench for the periodic wrap cell binning unit.
module periodic_wrap_cell_binning_unit_tb
    import pwcb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXIS_CELL_BITS = 10;
    localparam int RESULT_LATENCY = 3;
    localparam int MAX_REPORTS    = 200;
    localparam int PHASE_ITEMS    = 106;
    // No register lives at this index, so writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // One binned particle as the block should present it.
    typedef struct packed {
        logic [BOX_W-1:0] wrapped_x;
        logic [BOX_W-1:0] wrapped_y;
        logic [BOX_W-1:0] wrapped_z;
        logic [CNT_W-1:0] cell_index;
        logic             last_out;
    } bin_result_t;

    logic clk;
    logic rst_n;

    pwcb_particle_if particle();
    pwcb_result_if   result();
    pwcb_cfg_if      cfg();

    periodic_wrap_cell_binning_unit #(
        .AXIS_CELL_BITS(AXIS_CELL_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .particle (particle),
        .result   (result),
        .cfg      (cfg)
    );

    // Local copy of the box geometry, updated on every accepted register write.
    logic [BOX_W-1:0]   box_len_cfg [NUM_AXES];
    logic [RECIP_W-1:0] recip_cfg [NUM_AXES];
    logic [CNT_W-1:0]   cell_counts_cfg;

    bin_result_t expected_bins[$];
    int          mismatches;
    int          reports;
    int          hold_request;
    bit          rx_throttle;

    // Free-running clock, 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Predicted binning of one particle under the current geometry.
    function automatic bin_result_t bin_particle(input logic [POS_W-1:0] px,
                                                 input logic [POS_W-1:0] py,
                                                 input logic [POS_W-1:0] pz,
                                                 input logic last);
        logic [POS_W-1:0]  coord [NUM_AXES];
        logic [63:0]       cells [NUM_AXES];
        logic [63:0]       idx [NUM_AXES];
        logic [BOX_W-1:0]  wrapped [NUM_AXES];
        logic [63:0]       prod;
        logic [63:0]       scaled;
        logic [63:0]       cell_num;
        logic [FRAC_W-1:0] frac;
        bin_result_t       res;
        coord[AX_X] = px;
        coord[AX_Y] = py;
        coord[AX_Z] = pz;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            // An axis with a zero count behaves as a single cell.
            cells[a] = (64'(cell_counts_cfg) >> (a * AXIS_CELL_BITS))
                       & ((64'd1 << AXIS_CELL_BITS) - 64'd1);
            if (cells[a] == 64'd0)
                cells[a] = 64'd1;
            // Q16.16 times Q0.32; the fractional part modulo one does the wrap.
            prod       = {{32{coord[a][POS_W-1]}}, coord[a]} * {32'd0, recip_cfg[a]};
            frac       = prod[FRAC_LSB +: FRAC_W];
            idx[a]     = ({32'd0, frac} * cells[a]) >> 32;
            scaled     = ({32'd0, frac} * {33'd0, box_len_cfg[a]}) >> 32;
            wrapped[a] = scaled[BOX_W-1:0];
        end
        cell_num = idx[AX_X] + (idx[AX_Y] + idx[AX_Z] * cells[AX_Y]) * cells[AX_X];
        res.wrapped_x  = wrapped[AX_X];
        res.wrapped_y  = wrapped[AX_Y];
        res.wrapped_z  = wrapped[AX_Z];
        res.cell_index = cell_num[CNT_W-1:0];
        res.last_out   = last;
        return res;
    endfunction

    // Reciprocal in Q0.32 matching a Q16.16 box length, saturated below one.
    function automatic logic [RECIP_W-1:0] recip_for(input logic [31:0] box);
        logic [63:0] q;
        q = (64'd1 << 48) / {32'd0, box};
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[RECIP_W-1:0];
    endfunction

    // Random coordinate, biased towards the box and its edges.
    function automatic logic [POS_W-1:0] pick_coord(input int axis);
        logic [POS_W-1:0] box;
        logic [POS_W-1:0] c;
        box = {1'b0, box_len_cfg[axis]};
        case ($urandom_range(0, 7))
            0, 1, 2: c = $urandom_range(0, box - 32'd1);
            3:       c = ($urandom_range(0, 1) ? box : 32'd0) + $urandom_range(0, 4) - 32'd2;
            4:       c = -$urandom_range(1, box);
            5:       c = box * ($urandom_range(0, 10) - 32'd5) + $urandom_range(0, box - 32'd1);
            default: c = $urandom();
        endcase
        return c;
    endfunction

    // Random box length of at least one unit, most often modest and with a fractional part.
    function automatic logic [31:0] pick_box();
        logic [31:0] b;
        case ($urandom_range(0, 3))
            0:       b = $urandom_range(1, 64) << 16;
            1:       b = $urandom_range(65536, 32'h7FFF_FFFF);
            default: b = ($urandom_range(1, 1000) << 16) | $urandom_range(0, 16'hFFFF);
        endcase
        return b;
    endfunction

    // Report one field of a result against its prediction.
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (reports < MAX_REPORTS)
            begin
                reports++;
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        end
    endtask

    // Offer one particle and hold it until the block takes it.
    task automatic send_particle(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                 input logic [POS_W-1:0] pz, input logic last);
        particle.valid   <= 1'b1;
        particle.pos_x   <= px;
        particle.pos_y   <= py;
        particle.pos_z   <= pz;
        particle.last_in <= last;
        @(posedge clk);
        while (!particle.ready)
            @(posedge clk);
        expected_bins.push_back(bin_particle(px, py, pz, last));
        @(negedge clk);
    endtask

    task automatic send_random_particle();
        send_particle(pick_coord(AX_X), pick_coord(AX_Y), pick_coord(AX_Z),
                      $urandom_range(0, 5) == 0);
    endtask

    task automatic pause_sender(input int cycles);
        particle.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Stop sending until every outstanding result has come back.
    task automatic wait_results_drained();
        particle.valid <= 1'b0;
        while (expected_bins.size() != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 2) @(negedge clk);
    endtask

    // One register write transaction; valid is left high for back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_BOX_LEN_X:   box_len_cfg[AX_X] = value[BOX_W-1:0];
            REG_BOX_LEN_Y:   box_len_cfg[AX_Y] = value[BOX_W-1:0];
            REG_BOX_LEN_Z:   box_len_cfg[AX_Z] = value[BOX_W-1:0];
            REG_RECIP_X:     recip_cfg[AX_X]   = value;
            REG_RECIP_Y:     recip_cfg[AX_Y]   = value;
            REG_RECIP_Z:     recip_cfg[AX_Z]   = value;
            REG_CELL_COUNTS: cell_counts_cfg   = value[CNT_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
    endtask

    // Program the whole geometry; only called with the block idle.
    task automatic apply_geometry(input logic [31:0] bx, input logic [31:0] by,
                                  input logic [31:0] bz, input logic [31:0] rx,
                                  input logic [31:0] ry, input logic [31:0] rz,
                                  input logic [31:0] counts);
        write_reg(REG_BOX_LEN_X, bx);
        write_reg(REG_BOX_LEN_Y, by);
        write_reg(REG_BOX_LEN_Z, bz);
        write_reg(REG_RECIP_X, rx);
        write_reg(REG_RECIP_Y, ry);
        write_reg(REG_RECIP_Z, rz);
        write_reg(REG_CELL_COUNTS, counts);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_random_geometry();
        logic [31:0] b [NUM_AXES];
        logic [31:0] r [NUM_AXES];
        logic [31:0] counts;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            b[a] = pick_box();
            // Now and then the reciprocal has nothing to do with the length.
            if ($urandom_range(0, 4) == 0)
                r[a] = $urandom_range(1, 32'hFFFF_FFFF);
            else
                r[a] = recip_for(b[a]);
        end
        counts = 32'd0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if ($urandom_range(0, 15) == 0)
                counts[a * AXIS_CELL_BITS +: AXIS_CELL_BITS] = '0;
            else if ($urandom_range(0, 1) == 0)
                counts[a * AXIS_CELL_BITS +: AXIS_CELL_BITS] = $urandom_range(1, 16);
            else
                counts[a * AXIS_CELL_BITS +: AXIS_CELL_BITS] = $urandom_range(1, 1023);
        end
        apply_geometry(b[AX_X], b[AX_Y], b[AX_Z], r[AX_X], r[AX_Y], r[AX_Z], counts);
    endtask

    // Reset geometry: unit box, single cell, positions at the coordinate extremes.
    task automatic test_unit_box_extremes();
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
        send_particle(32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0001, 1'b1);
        wait_results_drained();
    endtask

    // Particles many box lengths outside must still wrap into the box.
    task automatic test_far_outside_wrap();
        apply_geometry(32'h000A_0000, 32'h000A_0000, 32'h000A_0000,
                       recip_for(32'h000A_0000), recip_for(32'h000A_0000),
                       recip_for(32'h000A_0000), (3 << 20) | (5 << 10) | 8);
        send_particle(32'h0019_8000, 32'hFFE6_8000, 32'h000A_0000, 1'b0);
        send_particle(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_particle(32'hFFF6_0000, 32'h0000_0000, 32'h0009_FFFF, 1'b0);
        send_particle(32'h1234_5678, 32'hEDCB_A987, 32'hFF9C_0001, 1'b1);
        wait_results_drained();
    endtask

    // Zero cell counts, over-wide register values and a write to an unused index.
    task automatic test_zero_cells_and_masking();
        apply_geometry(32'h8014_0000, 32'hFFFF_FFFF, 32'h8001_0000,
                       recip_for(32'h0014_0000), 32'h0000_0001, 32'hFFFF_FFFF,
                       32'hC000_0000 | (7 << 10));
        write_reg(REG_SPARE, 32'hDEAD_BEEF);
        cfg.valid <= 1'b0;
        @(negedge clk);
        send_particle(32'h0013_FFFF, 32'h7FFF_FFFF, 32'h0000_8000, 1'b0);
        send_particle(32'hFFFF_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_particle(32'h0005_0000, 32'h4000_0000, 32'h0001_0000, 1'b0);
        wait_results_drained();
    endtask

    // Length and reciprocal that disagree, with the largest cell counts.
    task automatic test_inconsistent_box();
        apply_geometry(32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000,
                       32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h3FFF_FFFF);
        send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_particle(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 1'b1);
        send_particle(32'h0000_0001, 32'hFFFF_0001, 32'hFFFF_8000, 1'b0);
        wait_results_drained();
    endtask

    // The receiver holds off for a long stretch while particles keep coming.
    task automatic test_output_backpressure();
        apply_random_geometry();
        rx_throttle  = 1'b0;
        hold_request = 48;
        repeat (30) send_random_particle();
        wait_results_drained();
    endtask

    // Bursty random traffic over several geometries.
    task automatic test_random_traffic();
        int sent;
        int burst;
        for (int phase = 0; phase < 8; phase++)
        begin
            apply_random_geometry();
            rx_throttle = (phase % 3) != 0;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && sent < PHASE_ITEMS; b++)
                begin
                    send_random_particle();
                    sent++;
                end
                // The first phase streams without any gap on the sending side.
                if (phase != 0 && $urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 6));
            end
            wait_results_drained();
        end
    endtask

    // Result side: ready follows its own run/stall pattern, or a requested hold.
    initial
    begin : result_sink
        int run_left;
        bit stalling;
        run_left     = 0;
        stalling     = 1'b0;
        result.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                result.ready <= 1'b0;
                repeat (hold_request - 1) @(negedge clk);
                hold_request = 0;
            end
            else if (!rx_throttle)
                result.ready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    stalling = !stalling;
                    run_left = stalling ? $urandom_range(1, 4) : $urandom_range(1, 10);
                end
                result.ready <= !stalling;
                run_left--;
            end
        end
    end

    // Compare every result transaction with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        bin_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_bins.size() == 0)
            begin
                mismatches++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("%0t ns: result with none expected, actual cell %h",
                             $time, result.cell_index);
                end
            end
            else
            begin
                want = expected_bins.pop_front();
                compare_field("wrapped_x", 32'(want.wrapped_x), 32'(result.wrapped_x));
                compare_field("wrapped_y", 32'(want.wrapped_y), 32'(result.wrapped_y));
                compare_field("wrapped_z", 32'(want.wrapped_z), 32'(result.wrapped_z));
                compare_field("cell_index", 32'(want.cell_index), 32'(result.cell_index));
                compare_field("last_out", 32'(want.last_out), 32'(result.last_out));
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        #2_000_000;
        $display("[periodic_wrap_cell_binning_unit] ERROR");
        $finish;
    end

    // Test sequence.
    initial
    begin
        mismatches       = 0;
        reports          = 0;
        hold_request     = 0;
        rx_throttle      = 1'b0;
        rst_n            = 1'b0;
        particle.valid   = 1'b0;
        particle.pos_x   = '0;
        particle.pos_y   = '0;
        particle.pos_z   = '0;
        particle.last_in = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.data         = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            box_len_cfg[a] = BOX_LEN_RESET;
            recip_cfg[a]   = RECIP_RESET;
        end
        cell_counts_cfg = CELL_COUNTS_RESET;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_unit_box_extremes();
        test_far_outside_wrap();
        test_zero_cells_and_masking();
        test_inconsistent_box();
        test_output_backpressure();
        test_random_traffic();

        // Allow stray results to show up before the verdict.
        wait_results_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && expected_bins.size() == 0)
            $display("[periodic_wrap_cell_binning_unit] OK");
        else
            $display("[periodic_wrap_cell_binning_unit] ERROR");
        $finish;
    end

endmodule
